// ===== rtl/sphere_constraint_solver_top_macros.svh =====
// Assertion macros for the sphere constraint solver.
// Expects clk and rst in scope of the module that uses them.
`ifndef SPHERE_CONSTRAINT_SOLVER_TOP_MACROS_SVH
`define SPHERE_CONSTRAINT_SOLVER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/scs_pkg.sv =====
// Shared types, constants and fixed-point helpers for the sphere constraint solver.
// No dependencies.
package scs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ITER_CAP  = 64;
  localparam int ADDR_W    = 5;
  localparam int DIV_STEPS = 31;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] wide_t;

  typedef enum logic [2:0] {
    REG_RADIUS, REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z,
    REG_STIFFNESS, REG_FRICTION, REG_TOLERANCE, REG_MAX_ITER
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] radius;
    word_t       center_x;
    word_t       center_y;
    word_t       center_z;
    logic [30:0] stiffness_gain;
    logic [30:0] friction_gain;
    logic [30:0] tolerance;
    logic [6:0]  max_iterations;
  } cfg_t;

  typedef struct packed {
    logic  req_type;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t vel_x;
    word_t vel_y;
    word_t vel_z;
    word_t acc_x;
    word_t acc_y;
    word_t acc_z;
  } item_t;

  typedef struct packed {
    word_t       out_x;
    word_t       out_y;
    word_t       out_z;
    logic [30:0] norm_squared;
    logic        degenerate;
  } result_t;

  typedef struct packed {
    logic        start;
    wide_t       num;
    logic [30:0] den;
  } div_req_t;

  typedef enum logic [1:0] {DOT_NN, DOT_NA, DOT_VV, DOT_VN} dot_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RR_MUL, S_RR_W, S_TOL_MUL, S_TOL_W, S_NSUB,
    S_DOT_MUL, S_DOT_ACC, S_DOT_END,
    S_K1_WAIT, S_KS_MUL, S_KS_W, S_KF_MUL, S_KF_W, S_K2_WAIT,
    S_R_MUL1, S_R_W1, S_R_MUL2, S_R_W2,
    S_LOOP, S_P_MUL, S_P_DIV, S_P_DWAIT, S_P_SQ, S_P_ACC,
    S_OUT
  } state_t;

  // Clamp a wide signed value to 32 bit signed
  function automatic word_t sat32(input wide_t v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Saturating subtract
  function automatic word_t fsub(input word_t a, input word_t b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return d[31:0];
  endfunction

  // Floor-shift an exact product back to Q format and saturate
  function automatic word_t fix_mul(input wide_t p);
    return sat32(p >>> FRAC_BITS);
  endfunction

  // Scale a word up by the fraction width as a division numerator
  function automatic wide_t frac_up(input word_t a);
    return wide_t'(a) <<< FRAC_BITS;
  endfunction

endpackage

// ===== rtl/scs_alu.sv =====
// Shared arithmetic unit: one registered 32x32 multiplier and a radix-2 divider.
// Depends on scs_pkg and the assertion macro header.
`include "sphere_constraint_solver_top_macros.svh"

module scs_alu
  import scs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  word_t    ma,
  input  word_t    mb,
  output wide_t    prod,
  input  div_req_t div_req,
  output logic     div_done,
  output word_t    div_q
);

  logic        div_busy;
  logic        neg;
  logic [30:0] den_r;
  logic [30:0] rem;
  logic [30:0] lo;
  logic [30:0] q;
  logic [4:0]  dcnt;
  logic [63:0] mag;
  logic [32:0] hi;
  logic [31:0] t;
  logic        ge;
  logic [30:0] rem_next;
  logic [30:0] q_next;

  // Register each exact product
  always_ff @(posedge clk) begin
    prod <= wide_t'(ma) * wide_t'(mb);
  end

  // Split the numerator magnitude for the overflow check
  always_comb begin
    mag = div_req.num[63] ? 64'(-div_req.num) : 64'(div_req.num);
    hi  = mag[63:31];
  end

  // One quotient bit per cycle
  always_comb begin
    t        = {rem, lo[30]};
    ge       = t >= {1'b0, den_r};
    rem_next = ge ? 31'(t - {1'b0, den_r}) : t[30:0];
    q_next   = {q[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (div_req.start) begin
        neg   <= div_req.num[63];
        den_r <= div_req.den;
        if (hi >= {2'b0, div_req.den}) begin
          // quotient magnitude reaches 2^31: saturate at once
          div_done <= 1'b1;
          div_q    <= div_req.num[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          div_busy <= 1'b1;
          rem      <= hi[30:0];
          lo       <= mag[30:0];
          q        <= '0;
          dcnt     <= '0;
        end
      end else if (div_busy) begin
        rem  <= rem_next;
        lo   <= {lo[29:0], 1'b0};
        q    <= q_next;
        dcnt <= dcnt + 5'd1;
        if (dcnt == 5'(DIV_STEPS - 1)) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
          div_q    <= neg ? 32'sd0 - word_t'({1'b0, q_next}) : word_t'({1'b0, q_next});
        end
      end
    end
  end

  `SCS_ASSERT_IMP(a_start_idle, div_req.start, !div_busy, "divide started while busy")
  `SCS_ASSERT_IMP(a_done_idle, div_done, !div_busy, "divide done while still busy")
  `SCS_ASSERT_IMP(a_busy_end, $fell(div_busy) && !$past(rst), div_done, "divide ended silently")
  `SCS_ASSERT_NXT(a_done_pulse, div_done, !div_done, "divide done held over two cycles")

endmodule

// ===== rtl/scs_core.sv =====
// Sequencer and datapath registers for both solver modes.
// Depends on scs_pkg and scs_alu.
module scs_core
  import scs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  state_t      state, state_next;
  dot_sel_t    dot_sel;
  logic        mode;
  logic        looping;
  logic        deg;
  logic [1:0]  cnt;
  logic [6:0]  iters_left;
  word_t       x [3];
  word_t       v [3];
  word_t       a [3];
  word_t       n [3];
  word_t       res [3];
  word_t       rr, c, k1, k2, num, tmp, d;
  logic [30:0] n2;
  logic [30:0] norm;
  logic [63:0] tol2;
  logic [63:0] step2;
  wide_t       acc;

  word_t       ma, mb;
  wide_t       prod;
  div_req_t    div_req;
  logic        div_done;
  word_t       div_q;

  word_t       dot_val;
  logic [30:0] n2v;
  word_t       pmul;
  word_t       num_kf;
  word_t       x1;
  logic        stop;

  scs_alu u_alu (
    .clk     (clk),
    .rst     (rst),
    .ma      (ma),
    .mb      (mb),
    .prod    (prod),
    .div_req (div_req),
    .div_done(div_done),
    .div_q   (div_q)
  );

  // Derived values from the latest product and accumulator
  always_comb begin
    dot_val = sat32(acc);
    n2v     = dot_val[31] ? 31'd0 : dot_val[30:0];
    pmul    = fix_mul(prod);
    num_kf  = fsub(num, pmul);
    x1      = fsub(x[cnt], div_q);
    stop    = (step2 < tol2) || (iters_left == 7'd1);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_RR_MUL;
      S_RR_MUL:  state_next = S_RR_W;
      S_RR_W:    state_next = S_TOL_MUL;
      S_TOL_MUL: state_next = S_TOL_W;
      S_TOL_W:   state_next = S_NSUB;
      S_NSUB:    state_next = S_DOT_MUL;
      S_DOT_MUL: state_next = S_DOT_ACC;
      S_DOT_ACC: state_next = (cnt == 2'd2) ? S_DOT_END : S_DOT_MUL;
      S_DOT_END: begin
        unique case (dot_sel)
          DOT_NN: begin
            if (!mode) state_next = (n2v == '0) ? S_OUT : S_DOT_MUL;
            else if (!looping) state_next = (iters_left == '0) ? S_OUT : S_LOOP;
            else state_next = stop ? S_OUT : S_LOOP;
          end
          DOT_NA: state_next = S_K1_WAIT;
          DOT_VV: state_next = S_KS_MUL;
          DOT_VN: state_next = S_KF_MUL;
        endcase
      end
      S_K1_WAIT: if (div_done) state_next = S_DOT_MUL;
      S_KS_MUL:  state_next = S_KS_W;
      S_KS_W:    state_next = S_DOT_MUL;
      S_KF_MUL:  state_next = S_KF_W;
      S_KF_W:    state_next = S_K2_WAIT;
      S_K2_WAIT: if (div_done) state_next = S_R_MUL1;
      S_R_MUL1:  state_next = S_R_W1;
      S_R_W1:    state_next = S_R_MUL2;
      S_R_MUL2:  state_next = S_R_W2;
      S_R_W2:    state_next = (cnt == 2'd2) ? S_OUT : S_R_MUL1;
      S_LOOP:    state_next = (n2 == '0) ? S_OUT : S_P_MUL;
      S_P_MUL:   state_next = S_P_DIV;
      S_P_DIV:   state_next = S_P_DWAIT;
      S_P_DWAIT: if (div_done) state_next = S_P_SQ;
      S_P_SQ:    state_next = S_P_ACC;
      S_P_ACC:   state_next = (cnt == 2'd2) ? S_NSUB : S_P_MUL;
      S_OUT:     if (out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Shared unit operands, divider requests and handshake
  always_comb begin
    ma          = '0;
    mb          = '0;
    div_req     = '0;
    div_req.den = n2;
    in_ready    = (state == S_IDLE);
    out_valid   = (state == S_OUT);
    unique case (state)
      S_RR_MUL: begin
        ma = word_t'({1'b0, cfg.radius});
        mb = word_t'({1'b0, cfg.radius});
      end
      S_TOL_MUL: begin
        ma = word_t'({1'b0, cfg.tolerance});
        mb = word_t'({1'b0, cfg.tolerance});
      end
      S_DOT_MUL: begin
        unique case (dot_sel)
          DOT_NN: begin ma = n[cnt]; mb = n[cnt]; end
          DOT_NA: begin ma = n[cnt]; mb = a[cnt]; end
          DOT_VV: begin ma = v[cnt]; mb = v[cnt]; end
          DOT_VN: begin ma = v[cnt]; mb = n[cnt]; end
        endcase
      end
      S_DOT_END: begin
        if (dot_sel == DOT_NA) begin
          div_req.start = 1'b1;
          div_req.num   = frac_up(dot_val);
        end
      end
      S_KS_MUL: begin ma = word_t'({1'b0, cfg.stiffness_gain}); mb = c; end
      S_KF_MUL: begin ma = word_t'({1'b0, cfg.friction_gain}); mb = tmp; end
      S_KF_W: begin
        div_req.start = 1'b1;
        div_req.num   = frac_up(num_kf);
      end
      S_R_MUL1: begin ma = k1; mb = n[cnt]; end
      S_R_MUL2: begin ma = k2; mb = n[cnt]; end
      S_P_MUL:  begin ma = c; mb = n[cnt]; end
      S_P_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = prod;
      end
      S_P_SQ:   begin ma = d; mb = d; end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      looping <= 1'b0;
      cnt     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode    <= in_item.req_type;
            looping <= 1'b0;
            deg     <= 1'b0;
            norm    <= '0;
            x[0] <= in_item.pos_x; x[1] <= in_item.pos_y; x[2] <= in_item.pos_z;
            v[0] <= in_item.vel_x; v[1] <= in_item.vel_y; v[2] <= in_item.vel_z;
            a[0] <= in_item.acc_x; a[1] <= in_item.acc_y; a[2] <= in_item.acc_z;
            iters_left <= (cfg.max_iterations > 7'(ITER_CAP)) ? 7'(ITER_CAP)
                                                             : cfg.max_iterations;
          end
        end
        S_RR_W:  rr   <= pmul;
        S_TOL_W: tol2 <= prod;
        S_NSUB: begin
          n[0]    <= fsub(x[0], cfg.center_x);
          n[1]    <= fsub(x[1], cfg.center_y);
          n[2]    <= fsub(x[2], cfg.center_z);
          acc     <= '0;
          cnt     <= '0;
          dot_sel <= DOT_NN;
        end
        S_DOT_ACC: begin
          acc <= acc + (prod >>> FRAC_BITS);
          cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
        end
        S_DOT_END: begin
          unique case (dot_sel)
            DOT_NN: begin
              n2 <= n2v;
              c  <= fsub(word_t'({1'b0, n2v}), rr);
              if (!mode) begin
                if (n2v == '0) begin
                  res <= a;
                  deg <= 1'b1;
                end else begin
                  norm    <= n2v;
                  dot_sel <= DOT_NA;
                  acc     <= '0;
                end
              end else if (!looping) begin
                looping <= 1'b1;
                if (iters_left == '0) begin
                  res <= x;
                  deg <= 1'b1;
                end
              end else begin
                iters_left <= iters_left - 7'd1;
                if (stop) res <= x;
              end
            end
            DOT_VV: num <= dot_val;
            DOT_VN: tmp <= dot_val;
            default: ;
          endcase
        end
        S_K1_WAIT: begin
          if (div_done) begin
            k1      <= div_q;
            dot_sel <= DOT_VV;
            acc     <= '0;
          end
        end
        S_KS_W: begin
          num     <= fsub(num, pmul);
          dot_sel <= DOT_VN;
          acc     <= '0;
        end
        S_K2_WAIT: if (div_done) k2 <= div_q;
        S_R_W1: res[cnt] <= fsub(a[cnt], pmul);
        S_R_W2: begin
          res[cnt] <= fsub(res[cnt], pmul);
          cnt      <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
        end
        S_LOOP: begin
          if (n2 == '0) begin
            res <= x;
            deg <= 1'b1;
          end
          step2 <= '0;
          cnt   <= '0;
        end
        S_P_DWAIT: begin
          if (div_done) begin
            x[cnt] <= x1;
            d      <= fsub(x1, x[cnt]);
          end
        end
        S_P_ACC: begin
          step2 <= step2 + prod;
          cnt   <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Hold the result while it waits
  always_comb begin
    out_res.out_x        = res[0];
    out_res.out_y        = res[1];
    out_res.out_z        = res[2];
    out_res.norm_squared = norm;
    out_res.degenerate   = deg;
  end

endmodule

// ===== rtl/sphere_constraint_solver_top.sv =====
// Sphere constraint solver: one request at a time through a shared multiplier and divider.
// Each quotient holds the sequencer while the radix-2 divider works (a saturated one returns at once);
// a new request is taken only after the last result has been accepted and the core is back in idle.
// Synchronous active-high reset returns the sequencer to idle and the registers
// to their reset values.
module sphere_constraint_solver_top
  import scs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
  input  logic [287:0]      s_tdata,
  // req_type
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // out_x, out_y, out_z, norm_squared, one zero pad bit
  output logic [127:0]      m_tdata,
  // degenerate
  output logic              m_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg;
  item_t    item;
  result_t  res;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius         <= 31'd65536;
      cfg.center_x       <= '0;
      cfg.center_y       <= '0;
      cfg.center_z       <= '0;
      cfg.stiffness_gain <= '0;
      cfg.friction_gain  <= '0;
      cfg.tolerance      <= 31'd66;
      cfg.max_iterations <= 7'd16;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_RADIUS:    cfg.radius         <= pwdata[30:0];
        REG_CENTER_X:  cfg.center_x       <= pwdata;
        REG_CENTER_Y:  cfg.center_y       <= pwdata;
        REG_CENTER_Z:  cfg.center_z       <= pwdata;
        REG_STIFFNESS: cfg.stiffness_gain <= pwdata[30:0];
        REG_FRICTION:  cfg.friction_gain  <= pwdata[30:0];
        REG_TOLERANCE: cfg.tolerance      <= pwdata[30:0];
        REG_MAX_ITER:  cfg.max_iterations <= pwdata[6:0];
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (idx)
      REG_RADIUS:    prdata = {1'b0, cfg.radius};
      REG_CENTER_X:  prdata = cfg.center_x;
      REG_CENTER_Y:  prdata = cfg.center_y;
      REG_CENTER_Z:  prdata = cfg.center_z;
      REG_STIFFNESS: prdata = {1'b0, cfg.stiffness_gain};
      REG_FRICTION:  prdata = {1'b0, cfg.friction_gain};
      REG_TOLERANCE: prdata = {1'b0, cfg.tolerance};
      REG_MAX_ITER:  prdata = {25'd0, cfg.max_iterations};
    endcase
  end

  // Unpack the request
  always_comb begin
    item.req_type = s_tuser;
    item.pos_x    = s_tdata[31:0];
    item.pos_y    = s_tdata[63:32];
    item.pos_z    = s_tdata[95:64];
    item.vel_x    = s_tdata[127:96];
    item.vel_y    = s_tdata[159:128];
    item.vel_z    = s_tdata[191:160];
    item.acc_x    = s_tdata[223:192];
    item.acc_y    = s_tdata[255:224];
    item.acc_z    = s_tdata[287:256];
  end

  scs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (item),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (res)
  );

  // Pack the result
  assign m_tdata = {1'b0, res.norm_squared, res.out_z, res.out_y, res.out_x};
  assign m_tuser = res.degenerate;

endmodule
